@@ sv/csvft_pkg.sv @@
// ----------------------------------------------------------------------------
// csvft_pkg: shared types and constants for the CSV field tokenizer
// Result record layout, result kinds and the special byte values.
// ----------------------------------------------------------------------------
package csvft_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 16;

  localparam logic [BYTE_W-1:0] QUOTE_BYTE     = 8'h22;
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE   = 8'h0A;
  localparam logic [BYTE_W-1:0] SEPARATOR_RST  = 8'd44;

  typedef enum logic [1:0] {
    KIND_CONTENT    = 2'd0,
    KIND_FIELD_END  = 2'd1,
    KIND_LINE_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   content_byte;
    logic [COUNT_W-1:0]  field_length;
    logic [COUNT_W-1:0]  column_number;
    logic                line_end;
  } result_t;

endpackage

@@ sv/csv_field_tokenizer.sv @@
// ----------------------------------------------------------------------------
// csv_field_tokenizer: streaming CSV field splitter
// Quote-aware tokenizer emitting content bytes, field-end and error records.
// ----------------------------------------------------------------------------
// The parse state update is a short compare, select and increment path, so
// one text byte is taken per clock while in_ready is high; its result, if
// any, is registered in the output register, or in the skid register if the
// output register is still full. A two-entry output stage (result and skid
// registers) lets input flow while out_ready is low; in_ready drops only
// when the skid register is full. Bytes with no result (opening quotes,
// dropped line bytes) are taken too. The user must write the separator byte
// through cfg_wr_en/cfg_field_separator while the block is idle; not enforced.
module csv_field_tokenizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [csvft_pkg::BYTE_W-1:0]      cfg_field_separator,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [csvft_pkg::BYTE_W-1:0]      in_text_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [csvft_pkg::BYTE_W-1:0]      out_content_byte,
  output logic [csvft_pkg::COUNT_W-1:0]     out_field_length,
  output logic [csvft_pkg::COUNT_W-1:0]     out_column_number,
  output logic                              out_line_end
);

  logic [csvft_pkg::BYTE_W-1:0] separator_r;
  logic                         take;
  logic                         res_valid;
  csvft_pkg::result_t           res;

  logic                         out_valid_r, out_valid_nxt;
  logic                         skid_valid_r, skid_valid_nxt;
  csvft_pkg::result_t           out_r, out_nxt;
  csvft_pkg::result_t           skid_r, skid_nxt;
  logic                         drain;
  logic                         push;

  assign in_ready = !skid_valid_r;
  assign take     = in_valid && in_ready;
  assign push     = take && res_valid;
  assign drain    = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      separator_r <= csvft_pkg::SEPARATOR_RST;
    end else if (cfg_wr_en) begin
      separator_r <= cfg_field_separator;
    end
  end

  csvft_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .text_byte (in_text_byte),
    .separator (separator_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (drain) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r && !out_valid_nxt) begin
      // skid beat moves up; no push can happen while skid is full
      out_nxt        = skid_r;
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      if (out_valid_nxt) begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end else begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_content_byte  = out_r.content_byte;
  assign out_field_length  = out_r.field_length;
  assign out_column_number = out_r.column_number;
  assign out_line_end      = out_r.line_end;

endmodule

@@ sv/csvft_core.sv @@
// ----------------------------------------------------------------------------
// csvft_core: per-byte field parser
// Holds the quote, field and line state and forms at most one result
// record for each accepted byte.
// ----------------------------------------------------------------------------
module csvft_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic [csvft_pkg::BYTE_W-1:0]      text_byte,
  input  logic [csvft_pkg::BYTE_W-1:0]      separator,
  output logic                              res_valid,
  output csvft_pkg::result_t                res
);

  logic                           in_quoted_r,   in_quoted_nxt;
  logic                           quote_pend_r,  quote_pend_nxt;
  logic                           at_start_r,    at_start_nxt;
  logic                           dropping_r,    dropping_nxt;
  logic [csvft_pkg::COUNT_W-1:0]  length_r,      length_nxt;
  logic [csvft_pkg::COUNT_W-1:0]  column_r,      column_nxt;

  logic is_nl;
  logic is_quote;
  logic is_sep;

  assign is_nl    = (text_byte == csvft_pkg::NEWLINE_BYTE);
  assign is_quote = (text_byte == csvft_pkg::QUOTE_BYTE);
  assign is_sep   = (text_byte == separator);

  always_comb begin
    in_quoted_nxt  = in_quoted_r;
    quote_pend_nxt = quote_pend_r;
    at_start_nxt   = at_start_r;
    dropping_nxt   = dropping_r;
    length_nxt     = length_r;
    column_nxt     = column_r;
    res_valid      = 1'b0;
    res            = '0;
    res.kind       = csvft_pkg::KIND_CONTENT;

    if (dropping_r) begin
      if (is_nl) begin
        dropping_nxt   = 1'b0;
        in_quoted_nxt  = 1'b0;
        quote_pend_nxt = 1'b0;
        at_start_nxt   = 1'b1;
        length_nxt     = '0;
        column_nxt     = '0;
      end
    end else if (is_quote) begin
      if (at_start_r) begin
        in_quoted_nxt = 1'b1;
        at_start_nxt  = 1'b0;
      end else if (quote_pend_r) begin
        // doubled quote gives one quote character
        quote_pend_nxt   = 1'b0;
        at_start_nxt     = 1'b0;
        length_nxt       = (length_r == '1) ? length_r : length_r + 1'b1;
        res_valid        = 1'b1;
        res.content_byte = csvft_pkg::QUOTE_BYTE;
      end else begin
        quote_pend_nxt = 1'b1;
      end
    end else if (is_nl || is_sep) begin
      if (quote_pend_r && !in_quoted_r) begin
        // stray quote in an unquoted field
        in_quoted_nxt     = 1'b0;
        quote_pend_nxt    = 1'b0;
        at_start_nxt      = 1'b1;
        length_nxt        = '0;
        res_valid         = 1'b1;
        res.kind          = csvft_pkg::KIND_LINE_ERROR;
        res.column_number = column_r;
        res.line_end      = is_nl;
        if (is_nl) begin
          column_nxt = '0;
        end else begin
          dropping_nxt = 1'b1;
        end
      end else if (in_quoted_r && !quote_pend_r) begin
        at_start_nxt     = 1'b0;
        length_nxt       = (length_r == '1) ? length_r : length_r + 1'b1;
        res_valid        = 1'b1;
        res.content_byte = text_byte;
      end else begin
        in_quoted_nxt     = 1'b0;
        quote_pend_nxt    = 1'b0;
        at_start_nxt      = 1'b1;
        length_nxt        = '0;
        res_valid         = 1'b1;
        res.kind          = csvft_pkg::KIND_FIELD_END;
        res.field_length  = length_r;
        res.column_number = column_r;
        res.line_end      = is_nl;
        if (is_nl) begin
          column_nxt = '0;
        end else begin
          column_nxt = (column_r == '1) ? column_r : column_r + 1'b1;
        end
      end
    end else begin
      at_start_nxt     = 1'b0;
      length_nxt       = (length_r == '1) ? length_r : length_r + 1'b1;
      res_valid        = 1'b1;
      res.content_byte = text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quoted_r  <= 1'b0;
      quote_pend_r <= 1'b0;
      at_start_r   <= 1'b1;
      dropping_r   <= 1'b0;
      length_r     <= '0;
      column_r     <= '0;
    end else if (take) begin
      in_quoted_r  <= in_quoted_nxt;
      quote_pend_r <= quote_pend_nxt;
      at_start_r   <= at_start_nxt;
      dropping_r   <= dropping_nxt;
      length_r     <= length_nxt;
      column_r     <= column_nxt;
    end
  end

endmodule
